/* hw/rtl/wlmc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wlmc_pkg
// Types and constants shared by the wear-leveled monotonic counter.
// ----------------------------------------------------------------------------
package wlmc_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned NIB_W  = 4;

  // an erased flash word reads as all ones
  localparam logic [WORD_W-1:0] ERASED = '1;
  // increments above this limit load the count directly
  localparam logic [WORD_W-1:0] SET_LIMIT = 32'd256;
  // low byte of a count rebuilt from the erase mark
  localparam logic [7:0] RESTORE_LSB = 8'h01;
  // shift that turns a count into its erase-mark epoch
  localparam int unsigned EPOCH_SHIFT = 8;

  typedef struct packed {
    logic [WORD_W-1:0] amount;
    logic [NIB_W-1:0]  random_nibble;
  } req_t;

  typedef struct packed {
    logic [WORD_W-1:0] count;
    logic              restored;
    logic              stuck;
  } rsp_t;

  // write into the slot page
  typedef struct packed {
    logic              en;
    logic              clear;
    logic [WORD_W-1:0] data;
  } page_wr_t;

  // occupancy of the slot page
  typedef struct packed {
    logic empty;
    logic full;
  } page_status_t;

endpackage

/* hw/rtl/wlmc_page.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wlmc_page
// Page of counter slots in a synchronous memory with a fill count that marks
// the written prefix; the last written slot is read back through a register.
// ----------------------------------------------------------------------------
module wlmc_page
  import wlmc_pkg::*;
#(
  parameter int unsigned SLOTS = 256
) (
  input  logic              clk,
  input  logic              rst,
  input  page_wr_t          wr,
  output logic [WORD_W-1:0] last,
  output page_status_t      status
);

  localparam int unsigned AW = $clog2(SLOTS);
  localparam int unsigned CW = $clog2(SLOTS + 1);

  logic [WORD_W-1:0] mem [SLOTS];
  logic [CW-1:0]     fill;
  logic [CW-1:0]     fill_base;
  logic [CW-1:0]     fill_dec;
  logic [AW-1:0]     rd_addr;
  logic [AW-1:0]     wr_addr;
  logic [WORD_W-1:0] rd_data;

  // slots past the fill count are ignored, so they never need clearing
  assign fill_base = wr.clear ? '0 : fill;
  assign wr_addr   = fill_base[AW-1:0];
  assign fill_dec  = fill - CW'(1);
  assign rd_addr   = (fill == '0) ? '0 : fill_dec[AW-1:0];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr_addr] <= wr.data;
    end
    rd_data <= mem[rd_addr];
  end

  // an all-ones write reads as erased and does not extend the prefix
  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (wr.en) begin
      fill <= fill_base + CW'(wr.data != ERASED);
    end
  end

  assign last         = (fill == '0) ? '0 : rd_data;
  assign status.empty = (fill == '0);
  assign status.full  = (fill == CW'(SLOTS));

endmodule

/* hw/rtl/wear_leveled_monotonic_counter_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wear_leveled_monotonic_counter_unit
// Monotonic counter kept in a page of flash-like slots and an erase mark.
// ----------------------------------------------------------------------------
// Usage:
//   A request (amount, random_nibble) enters on req with req_valid/req_stall.
//   Each request gives exactly one response (count, restored, stuck) on rsp
//   with rsp_valid/rsp_stall, in request order.
//   The response is registered: the last written slot is read from the slot
//   memory at the accepting edge, and the update, write back and response
//   register load happen at the edge that ends the update cycle.
//   A new request is taken only once the last one is written back: after each
//   write back the unit returns to idle, where the next read sees the new slot.
//   The slot page keeps a fill count of its written prefix, so no scan of
//   the slots is needed and a full page is cleared by resetting the fill count.
//   The response sits in an output register; a new request is taken while it
//   waits, and that request holds in its update cycle while rsp_stall is
//   high, with req_stall high meanwhile.
//   Reset empties the page at once (no clearing pass), erases the erase mark
//   and zeroes the previously returned count.
// ----------------------------------------------------------------------------
module wear_leveled_monotonic_counter_unit
  import wlmc_pkg::*;
#(
  parameter int unsigned SLOTS = 256
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  localparam logic ST_IDLE   = 1'b0;
  localparam logic ST_UPDATE = 1'b1;

  logic              state;
  logic              state_next;
  req_t              req_q;
  logic [WORD_W-1:0] erase_mark;
  logic [WORD_W-1:0] erase_mark_next;
  logic [WORD_W-1:0] previous_count;

  logic [WORD_W-1:0] last;
  page_status_t      page_status;
  page_wr_t          page_wr;

  logic [WORD_W-1:0] mark_eff;
  logic [WORD_W-1:0] step;
  logic [WORD_W-1:0] count_new;
  logic [WORD_W-1:0] epoch;
  logic              restore;
  logic              commit;
  rsp_t              rsp_next;

  wlmc_page #(
    .SLOTS (SLOTS)
  ) u_page (
    .clk    (clk),
    .rst    (rst),
    .wr     (page_wr),
    .last   (last),
    .status (page_status)
  );

  assign req_stall = (state != ST_IDLE);
  assign commit    = (state == ST_UPDATE) && (!rsp_valid || !rsp_stall);

  always_comb begin
    mark_eff  = (erase_mark == ERASED) ? WORD_W'(1) : erase_mark;
    step      = (req_q.amount == '0) ? (WORD_W'(req_q.random_nibble) + WORD_W'(1))
                                     : req_q.amount;
    restore   = page_status.empty || (last == '0);
    count_new = (step > SET_LIMIT) ? step : (last + step);
    epoch     = count_new >> EPOCH_SHIFT;

    page_wr.en    = commit;
    page_wr.clear = 1'b0;
    page_wr.data  = count_new;
    rsp_next.restored = 1'b0;
    rsp_next.stuck    = (count_new == previous_count);
    rsp_next.count    = count_new;

    if (restore) begin
      page_wr.clear     = 1'b1;
      page_wr.data      = {mark_eff[WORD_W-9:0], RESTORE_LSB};
      rsp_next.count    = page_wr.data;
      rsp_next.restored = 1'b1;
      rsp_next.stuck    = 1'b0;
      erase_mark_next   = mark_eff + WORD_W'(1);
    end else if (page_status.full) begin
      page_wr.clear   = 1'b1;
      erase_mark_next = epoch + WORD_W'(1);
    end else begin
      erase_mark_next = (epoch > mark_eff) ? epoch : mark_eff;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req_valid) begin
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (commit) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      erase_mark     <= ERASED;
      previous_count <= '0;
      rsp_valid      <= 1'b0;
    end else begin
      state <= state_next;
      if (commit) begin
        erase_mark <= erase_mark_next;
        if (!restore) begin
          previous_count <= count_new;
        end
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && req_valid) begin
      req_q <= req;
    end
    if (commit) begin
      rsp <= rsp_next;
    end
  end

endmodule

/* bench/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the wear-leveled monotonic counter. Requests are
// driven in random bursts while the response side stalls on its own pattern.
// A behavioral image of the slot page, erase mark and last returned count
// predicts each response, which is compared field by field in order.
// ----------------------------------------------------------------------------
module tb;
  import wlmc_pkg::*;

  localparam int unsigned SLOTS     = 256;
  localparam int unsigned AW        = $clog2(SLOTS);
  localparam int unsigned CW        = $clog2(SLOTS + 1);
  localparam int unsigned IDLE_MAX  = 4000;
  localparam int unsigned HOLD_LEN  = 150;
  localparam int unsigned TAIL_WAIT = 10;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  // behavioral image of the counter state
  logic [WORD_W-1:0] slot_image [SLOTS];
  logic [WORD_W-1:0] mark_image;
  logic [WORD_W-1:0] last_returned;

  rsp_t pending_counts [$];
  int unsigned err_count = 0;
  int unsigned idle_cycles = 0;

  // sender burst state
  int unsigned burst_left = 0;
  bit gaps_on = 1'b1;
  logic [WORD_W-1:0] last_set_amount = 32'd1000;

  // receiver stall state
  int unsigned hold_asks = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;
  int unsigned stall_phase = 0;
  int unsigned stall_mode = 0;

  wear_leveled_monotonic_counter_unit #(
    .SLOTS(SLOTS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp(rsp)
  );

  always #2 clk = ~clk;

  function automatic void erase_page_image();
    foreach (slot_image[i]) slot_image[i] = ERASED;
  endfunction

  function automatic rsp_t advance_counter(req_t r);
    logic [WORD_W-1:0] step;
    logic [WORD_W-1:0] cur;
    logic [CW-1:0] fill;
    rsp_t res;
    res = '0;
    if (mark_image == ERASED) begin
      mark_image = 32'd1;
    end
    step = (r.amount == '0) ? WORD_W'(r.random_nibble) + 32'd1 : r.amount;
    cur = '0;
    fill = '0;
    // the last written slot ahead of the first erased one holds the count
    while (fill < SLOTS && slot_image[fill[AW-1:0]] != ERASED) begin
      cur = slot_image[fill[AW-1:0]];
      fill++;
    end
    if (cur == '0) begin
      // rebuild from the erase mark: mark * 256 + 1, modulo 2^32
      cur = {mark_image[WORD_W-EPOCH_SHIFT-1:0], RESTORE_LSB};
      erase_page_image();
      slot_image[0] = cur;
      mark_image = mark_image + 32'd1;
      res.count = cur;
      res.restored = 1'b1;
      return res;
    end
    cur = (step > SET_LIMIT) ? step : cur + step;
    if ((cur >> EPOCH_SHIFT) > mark_image) begin
      mark_image = cur >> EPOCH_SHIFT;
    end
    if (fill == SLOTS) begin
      mark_image = (cur >> EPOCH_SHIFT) + 32'd1;
      erase_page_image();
      fill = '0;
    end
    slot_image[fill[AW-1:0]] = cur;
    res.count = cur;
    res.stuck = (cur == last_returned);
    last_returned = cur;
    return res;
  endfunction

  // prediction on each accepted request, check on each accepted response
  always @(posedge clk) begin
    rsp_t exp_rsp;
    if (!rst) begin
      if (req_valid && !req_stall) begin
        pending_counts.push_back(advance_counter(req));
      end
      if (rsp_valid && !rsp_stall) begin
        if (pending_counts.size() == 0) begin
          $error("response with no request pending: count %h", rsp.count);
          err_count++;
        end else begin
          exp_rsp = pending_counts.pop_front();
          if (rsp.count !== exp_rsp.count) begin
            $error("count: expected %h, got %h", exp_rsp.count, rsp.count);
            err_count++;
          end
          if (rsp.restored !== exp_rsp.restored) begin
            $error("restored: expected %b, got %b", exp_rsp.restored, rsp.restored);
            err_count++;
          end
          if (rsp.stuck !== exp_rsp.stuck) begin
            $error("stuck: expected %b, got %b", exp_rsp.stuck, rsp.stuck);
            err_count++;
          end
        end
      end
    end
  end

  // watchdog on cycles where neither side moves
  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles == IDLE_MAX) begin
        $display("tb: done, errors");
        $finish;
      end
    end
  end

  // response side stall pattern, in a randomly switched mode
  always @(negedge clk) begin
    stall_phase++;
    if (stall_phase % 50 == 0) begin
      stall_mode = $urandom_range(3);
    end
    if (hold_seen != hold_asks) begin
      hold_seen = hold_asks;
      hold_left = HOLD_LEN;
    end
    if (hold_left > 0) begin
      hold_left--;
      rsp_stall <= 1'b1;
    end else begin
      case (stall_mode)
        0: rsp_stall <= 1'b0;
        1: rsp_stall <= ($urandom_range(1) == 0);
        2: rsp_stall <= ($urandom_range(3) == 0);
        default: rsp_stall <= (stall_phase % 3 == 0);
      endcase
    end
  end

  task automatic issue_request(input logic [WORD_W-1:0] amt, input logic [NIB_W-1:0] nib);
    int unsigned gap;
    @(negedge clk);
    req_valid <= 1'b1;
    req <= '{amount: amt, random_nibble: nib};
    do @(posedge clk); while (req_stall);
    if (burst_left > 0) begin
      burst_left--;
    end
    if (burst_left == 0 && gaps_on) begin
      burst_left = $urandom_range(24, 1);
      gap = $urandom_range(10, 1);
      @(negedge clk);
      req_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    req_valid <= 1'b0;
    while (pending_counts.size() != 0) @(posedge clk);
  endtask

  task automatic test_first_restore();
    // erased erase mark and empty page right after reset
    issue_request(32'd5, 4'h0);
    issue_request(32'd0, 4'h0);
    issue_request(32'd0, 4'hf);
  endtask

  task automatic test_increment_edges();
    issue_request(32'd1, 4'ha);
    issue_request(32'd256, 4'h5);
    issue_request(32'd257, 4'h3);
    issue_request(32'd0, 4'h7);
    issue_request(32'h0012_3456, 4'hc);
  endtask

  task automatic test_stuck_count();
    issue_request(32'd1000, 4'h1);
    issue_request(32'd1000, 4'h2);
    issue_request(32'd1000, 4'he);
  endtask

  task automatic test_wrap_to_zero();
    // count wraps to zero, so the next request rebuilds from a huge erase mark
    issue_request(32'hffff_ff00, 4'h0);
    issue_request(32'd256, 4'h0);
    issue_request(32'd3, 4'h9);
    issue_request(32'd0, 4'h4);
  endtask

  task automatic test_all_ones_write();
    // all ones reads back as erased, so the scan stops in front of it
    issue_request(32'hffff_ffff, 4'hf);
    issue_request(32'd2, 4'h6);
    issue_request(32'd2, 4'h8);
    wait_drained();
    // an increment that reaches all ones does not extend the prefix either
    issue_request(32'd0, 4'h0);
    issue_request(32'hffff_fffe, 4'h0);
    issue_request(32'd1, 4'h0);
  endtask

  task automatic test_full_page();
    // small increments only, so the page fills and is cleared
    repeat (300) begin
      issue_request($urandom_range(256), NIB_W'($urandom_range(15)));
    end
  endtask

  task automatic test_backpressure();
    wait_drained();
    gaps_on = 1'b0;
    hold_asks++;
    repeat (12) begin
      issue_request($urandom_range(40), NIB_W'($urandom_range(15)));
    end
    gaps_on = 1'b1;
    wait_drained();
  endtask

  task automatic test_random_mix();
    int unsigned pick;
    logic [WORD_W-1:0] amt;
    repeat (480) begin
      pick = $urandom_range(99);
      if (pick < 60) begin
        amt = $urandom_range(256);
      end else if (pick < 70) begin
        amt = '0;
      end else if (pick < 80) begin
        amt = $urandom_range(32'hffff_fffe, 32'd257);
        last_set_amount = amt;
      end else if (pick < 86) begin
        amt = $urandom;
      end else if (pick < 91) begin
        amt = 32'hffff_ff00 + $urandom_range(255);
      end else if (pick < 94) begin
        amt = ERASED;
      end else if (pick < 97) begin
        amt = last_set_amount;
      end else begin
        amt = ($urandom_range(1) == 0) ? 32'd256 : 32'd257;
      end
      issue_request(amt, NIB_W'($urandom_range(15)));
      if ($urandom_range(99) == 0) begin
        wait_drained();
      end
    end
  endtask

  initial begin
    erase_page_image();
    mark_image = ERASED;
    last_returned = '0;
    repeat (9) @(negedge clk);
    rst <= 1'b0;

    test_first_restore();
    test_increment_edges();
    test_stuck_count();
    test_wrap_to_zero();
    test_all_ones_write();
    test_full_page();
    test_backpressure();
    test_random_mix();

    wait_drained();
    repeat (TAIL_WAIT) @(posedge clk);
    if (pending_counts.size() != 0) begin
      $error("%0d responses never arrived", pending_counts.size());
      err_count++;
    end
    if (err_count == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
